// File: hw/rtl/fsdt_pkg.sv
// Package for the single-server tail-drop queue timer.
// Holds field widths, parameter defaults and the controller/datapath interface structs.
// No dependencies.
`default_nettype none
package fsdt_pkg;

	localparam int TIME_W = 48;
	localparam int DUR_W = 32;
	localparam int LIMIT_W = 11;
	localparam int MAX_QUEUE_DEF = 1024;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1;

	typedef struct packed {
		logic load;
		logic pop;
		logic commit;
	} fsdt_cmd_t;

	typedef struct packed {
		logic occ_nz;
		logic hit;
		logic last_pop;
		logic out_free;
	} fsdt_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/fsdt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module fsdt_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1025
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: hw/rtl/fsdt_ctrl.sv
// Controller state machine for the queue timer: accept, retire loop, decide.
// Depends on fsdt_pkg for the command and status structs.
`default_nettype none
module fsdt_ctrl
	import fsdt_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire fsdt_status_t status,
	output fsdt_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = status.occ_nz ? ST_CHECK : ST_DECIDE;
				end
			end
			ST_CHECK: begin
				if (status.hit) begin
					cmd.pop = 1'b1;
					state_d = status.last_pop ? ST_DECIDE : ST_CHECK;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/fsdt_dp.sv
// Datapath for the queue timer: finish-time ring, head and count, limit register, result register.
// Depends on fsdt_pkg and fsdt_ram.
`default_nettype none
module fsdt_dp
	import fsdt_pkg::*;
#(
	parameter int MAX_QUEUE = MAX_QUEUE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fsdt_cmd_t          cmd,
	output fsdt_status_t            status,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata,
	input  wire logic [TIME_W-1:0]  arrival_time,
	input  wire logic [DUR_W-1:0]   duration,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    rejected,
	output logic [TIME_W-1:0]       finish_time
);

	localparam int SLOTS = MAX_QUEUE + 1;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
	localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   occ_q;
	logic [TIME_W-1:0]  last_finish_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               out_valid_q;
	logic [TIME_W-1:0]  arrival_q;
	logic [DUR_W-1:0]   dur_q;
	logic [TIME_W-1:0]  start_q;
	logic               rejected_q;
	logic [TIME_W-1:0]  finish_q;

	logic [IDX_W-1:0]  head_next_c;
	logic [IDX_W-1:0]  raddr_c;
	logic [SUM_W-1:0]  wsum_c;
	logic [IDX_W-1:0]  waddr_c;
	logic [TIME_W-1:0] rdata;
	logic [LIM_W-1:0]  lim_c;
	logic [LIM_W-1:0]  occ_m1_c;
	logic              full_c;
	logic [TIME_W:0]   sum_c;
	logic [TIME_W-1:0] fin_c;
	logic              write_c;

	assign head_next_c = (head_q == IDX_W'(SLOTS - 1)) ? '0 : head_q + IDX_W'(1);
	assign raddr_c = cmd.pop ? head_next_c : head_q;

	assign wsum_c = SUM_W'(head_q) + SUM_W'(occ_q);
	assign waddr_c = (wsum_c >= SUM_W'(SLOTS)) ? IDX_W'(wsum_c - SUM_W'(SLOTS))
		: IDX_W'(wsum_c);

	assign lim_c = (LIM_W'(limit_q) > LIM_W'(MAX_QUEUE)) ? LIM_W'(MAX_QUEUE)
		: LIM_W'(limit_q);
	assign occ_m1_c = LIM_W'(occ_q) - LIM_W'(1);
	assign full_c = (occ_q != '0) && (occ_m1_c >= lim_c);

	assign sum_c = {1'b0, start_q} + (TIME_W + 1)'(dur_q);
	assign fin_c = sum_c[TIME_W] ? '1 : sum_c[TIME_W-1:0];

	assign write_c = cmd.commit && !full_c;

	fsdt_ram #(
		.WIDTH(TIME_W),
		.DEPTH(SLOTS)
	) u_ring (
		.clk  (clk),
		.we   (write_c),
		.waddr(waddr_c),
		.wdata(fin_c),
		.raddr(raddr_c),
		.rdata(rdata)
	);

	assign status.occ_nz = (occ_q != '0);
	assign status.hit = (rdata <= arrival_q);
	assign status.last_pop = (occ_q == CNT_W'(1));
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q <= '0;
			last_finish_q <= '0;
			limit_q <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.pop) begin
				head_q <= head_next_c;
				occ_q <= occ_q - CNT_W'(1);
			end
			if (write_c) begin
				occ_q <= occ_q + CNT_W'(1);
				last_finish_q <= fin_c;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			arrival_q <= arrival_time;
			dur_q <= duration;
			start_q <= (last_finish_q > arrival_time) ? last_finish_q : arrival_time;
		end
		if (cmd.commit) begin
			rejected_q <= full_c;
			finish_q <= full_c ? '0 : fin_c;
		end
	end

	assign out_valid = out_valid_q;
	assign rejected = rejected_q;
	assign finish_time = finish_q;

endmodule
`default_nettype wire

// File: hw/rtl/fifo_server_tail_drop_timer_top.sv
// Single-server queue timer with tail drop; one result per request.
// Steps: accept (load), the retire loop (skipped when the queue is empty) and decide, which waits for
// a free output register. The retire loop reads one ring entry per cycle.
// Throughput: the next request is taken the cycle after the result is registered.
// Reset clears head, count, last finish time and the result valid; the queue limit resets to 1.
// The finish-time ring needs no clearing pass: only written entries are ever used.
`default_nettype none
module fifo_server_tail_drop_timer_top
	import fsdt_pkg::*;
#(
	parameter int MAX_QUEUE = MAX_QUEUE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [TIME_W-1:0]  arrival_time,
	input  wire logic [DUR_W-1:0]   duration,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    rejected,
	output logic [TIME_W-1:0]       finish_time
);

	fsdt_cmd_t    cmd;
	fsdt_status_t status;

	fsdt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	fsdt_dp #(
		.MAX_QUEUE(MAX_QUEUE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.arrival_time(arrival_time),
		.duration    (duration),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rejected    (rejected),
		.finish_time (finish_time)
	);

endmodule
`default_nettype wire
